### rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int HEAP_BYTES_DEF      = 2048;
  localparam int HEADER_BYTES_DEF    = 16;
  localparam int FREE_LIST_DEPTH_DEF = 32;

  localparam int GRAN_SHIFT = 3;
  localparam int GRAN_BYTES = 8;

  localparam int REQ_W   = 12;
  localparam int OFS_W   = 11;
  localparam int BYTES_W = 12;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 12;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 12'd2048;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // register index taken from paddr[2]
  localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;

  typedef struct packed {
    logic               req_type;
    logic [REQ_W-1:0]   request_bytes;
    logic [OFS_W-1:0]   payload_offset;
  } ffa_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [OFS_W-1:0]   result_offset;
    logic [BYTES_W-1:0] block_bytes;
  } ffa_out_t;

endpackage
`default_nettype wire

### rtl/ffa_regs.sv
`default_nettype none
module ffa_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ffa_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ffa_pkg::APB_DW-1:0]  pwdata,
  output logic      [ffa_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [ffa_pkg::LIMIT_W-1:0] heap_limit
);

  logic [ffa_pkg::LIMIT_W-1:0] heap_limit_r, heap_limit_nxt;
  logic                        hit;
  logic                        wr;

  assign hit    = (paddr[2] == ffa_pkg::REG_HEAP_LIMIT);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    heap_limit_nxt = heap_limit_r;
    if (wr && hit) begin
      heap_limit_nxt = pwdata[ffa_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= ffa_pkg::HEAP_LIMIT_RST;
    end else begin
      heap_limit_r <= heap_limit_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = ffa_pkg::APB_DW'(heap_limit_r);
    end
  end

  assign heap_limit = heap_limit_r;

endmodule
`default_nettype wire

### rtl/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl #(
  parameter int HEAP_BYTES      = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
  parameter int FREE_LIST_DEPTH = ffa_pkg::FREE_LIST_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ffa_pkg::LIMIT_W-1:0] heap_limit,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ffa_pkg::ffa_in_t            in_item,
  output logic                             out_valid,
  output ffa_pkg::ffa_out_t                out_item
);

  localparam int GB     = ffa_pkg::GRAN_BYTES;
  localparam int GS     = ffa_pkg::GRAN_SHIFT;
  localparam int META   = ((HEADER_BYTES + GB - 1) / GB) * GB;
  localparam int GRANULES = HEAP_BYTES / GB;
  localparam int GW     = $clog2(GRANULES);
  localparam int SW     = $clog2(GRANULES + 1);
  localparam int BW     = $clog2(HEAP_BYTES + 1);
  localparam int NEED_W = ffa_pkg::REQ_W + 1;
  localparam int CW     = ((BW > NEED_W) ? BW : NEED_W) + 1;
  localparam int IW     = $clog2(FREE_LIST_DEPTH);
  localparam int NW     = $clog2(FREE_LIST_DEPTH + 1);
  localparam int FEW    = GW + SW;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_BUMP  = 3'd5;

  // granule table: {allocated, size in granules}; free list: {start, size}
  logic [SW:0]    gran_mem_r [GRANULES];
  logic [FEW-1:0] flist_mem_r [FREE_LIST_DEPTH];

  logic           gm_we, gm_re;
  logic [GW-1:0]  gm_waddr, gm_raddr;
  logic [SW:0]    gm_wdata, gm_rd_r;
  logic           fm_we, fm_re;
  logic [IW-1:0]  fm_waddr, fm_raddr;
  logic [FEW-1:0] fm_wdata, fm_rd_r;

  logic [2:0]        state_r, state_nxt;
  logic [GW-1:0]     clr_r, clr_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [GW-1:0]     gidx_r, gidx_nxt;
  logic              bad_r, bad_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [BW-1:0]     brk_r, brk_nxt;
  logic [GW-1:0]     hit_start_r, hit_start_nxt;
  logic [SW-1:0]     hit_size_r, hit_size_nxt;
  logic              out_valid_r, out_valid_nxt;
  ffa_pkg::ffa_out_t out_r, out_nxt;

  logic [NEED_W-1:0] need_raw;
  logic [NEED_W-1:0] need_in;
  logic [CW-1:0]     p_ext, fstart, limit, bump_end, bump_ofs;
  logic              free_bad, oom, fits;
  logic [GW-1:0]     fe_start;
  logic [SW-1:0]     fe_size;
  logic              g_alloc;
  logic [SW-1:0]     g_size;
  ffa_pkg::ffa_out_t reuse_ok;

  assign need_raw = NEED_W'(META) + NEED_W'(in_item.request_bytes) + NEED_W'(GB - 1);
  assign need_in  = {need_raw[NEED_W-1:GS], {GS{1'b0}}};

  assign p_ext    = CW'(in_item.payload_offset);
  assign fstart   = p_ext - CW'(META);
  assign free_bad = (p_ext < CW'(META)) || (fstart[GS-1:0] != '0) ||
                    (fstart >= CW'(brk_r));

  assign limit    = (CW'(heap_limit) < CW'(HEAP_BYTES)) ? CW'(heap_limit) : CW'(HEAP_BYTES);
  assign bump_end = CW'(brk_r) + CW'(need_r);
  assign bump_ofs = CW'(brk_r) + CW'(META);
  assign oom      = (bump_end > limit) || (bump_ofs >= CW'(HEAP_BYTES));

  assign fe_start = fm_rd_r[FEW-1:SW];
  assign fe_size  = fm_rd_r[SW-1:0];
  assign fits     = (CW'(fe_size) << GS) >= CW'(need_r);

  assign g_alloc  = gm_rd_r[SW];
  assign g_size   = gm_rd_r[SW-1:0];

  always_comb begin
    reuse_ok.status        = ffa_pkg::ST_OK;
    reuse_ok.result_offset = ffa_pkg::OFS_W'((CW'(hit_start_r) << GS) + CW'(META));
    reuse_ok.block_bytes   = ffa_pkg::BYTES_W'(CW'(hit_size_r) << GS);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    need_nxt      = need_r;
    gidx_nxt      = gidx_r;
    bad_nxt       = bad_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    brk_nxt       = brk_r;
    hit_start_nxt = hit_start_r;
    hit_size_nxt  = hit_size_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    gm_we    = 1'b0;
    gm_waddr = gidx_r;
    gm_wdata = '0;
    gm_re    = 1'b0;
    gm_raddr = fstart[GW+GS-1:GS];
    fm_we    = 1'b0;
    fm_waddr = idx_r;
    fm_wdata = fm_rd_r;
    fm_re    = 1'b0;
    fm_raddr = idx_r;

    unique case (state_r)
      S_CLR: begin
        gm_we    = 1'b1;
        gm_waddr = clr_r;
        gm_wdata = '0;
        if (clr_r == GW'(GRANULES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          need_nxt = need_in;
          if (in_item.req_type == ffa_pkg::REQ_FREE) begin
            bad_nxt   = free_bad;
            gidx_nxt  = fstart[GW+GS-1:GS];
            gm_re     = 1'b1;
            state_nxt = S_FREE;
          end else if (cnt_r == '0) begin
            state_nxt = S_BUMP;
          end else begin
            // newest entry first
            fm_re     = 1'b1;
            fm_raddr  = IW'(cnt_r - 1'b1);
            idx_nxt   = IW'(cnt_r - 1'b1);
            state_nxt = S_SRCH;
          end
        end
      end

      S_FREE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_nxt       = '0;
        if (bad_r || !g_alloc) begin
          out_nxt.status = ffa_pkg::ST_BAD;
        end else if (cnt_r == NW'(FREE_LIST_DEPTH)) begin
          out_nxt.status = ffa_pkg::ST_FULL;
        end else begin
          gm_we    = 1'b1;
          gm_wdata = {1'b0, g_size};
          fm_we    = 1'b1;
          fm_waddr = IW'(cnt_r);
          fm_wdata = {gidx_r, g_size};
          cnt_nxt  = cnt_r + 1'b1;
          out_nxt.status      = ffa_pkg::ST_OK;
          out_nxt.block_bytes = ffa_pkg::BYTES_W'(CW'(g_size) << GS);
        end
      end

      S_SRCH: begin
        if (fits) begin
          hit_start_nxt = fe_start;
          hit_size_nxt  = fe_size;
          gm_we    = 1'b1;
          gm_waddr = fe_start;
          gm_wdata = {1'b1, fe_size};
          if (NW'(idx_r) + 1'b1 == cnt_r) begin
            cnt_nxt       = cnt_r - 1'b1;
            out_valid_nxt = 1'b1;
            out_nxt.status        = ffa_pkg::ST_OK;
            out_nxt.result_offset = ffa_pkg::OFS_W'((CW'(fe_start) << GS) + CW'(META));
            out_nxt.block_bytes   = ffa_pkg::BYTES_W'(CW'(fe_size) << GS);
            state_nxt     = S_IDLE;
          end else begin
            // close the gap: move newer entries down one slot
            fm_re     = 1'b1;
            fm_raddr  = idx_r + 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (idx_r == '0) begin
          state_nxt = S_BUMP;
        end else begin
          fm_re    = 1'b1;
          fm_raddr = idx_r - 1'b1;
          idx_nxt  = idx_r - 1'b1;
        end
      end

      S_SHIFT: begin
        fm_we    = 1'b1;
        fm_waddr = idx_r;
        fm_wdata = fm_rd_r;
        if (NW'(idx_r) + NW'(2) == cnt_r) begin
          cnt_nxt       = cnt_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = reuse_ok;
          state_nxt     = S_IDLE;
        end else begin
          fm_re    = 1'b1;
          fm_raddr = IW'(NW'(idx_r) + NW'(2));
          idx_nxt  = idx_r + 1'b1;
        end
      end

      S_BUMP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_nxt       = '0;
        if (oom) begin
          out_nxt.status = ffa_pkg::ST_OOM;
        end else begin
          gm_we    = 1'b1;
          gm_waddr = brk_r[GW+GS-1:GS];
          gm_wdata = {1'b1, SW'(need_r >> GS)};
          brk_nxt  = brk_r + BW'(need_r);
          out_nxt.status        = ffa_pkg::ST_OK;
          out_nxt.result_offset = ffa_pkg::OFS_W'(bump_ofs);
          out_nxt.block_bytes   = ffa_pkg::BYTES_W'(need_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      brk_r       <= BW'(META);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    gidx_r      <= gidx_nxt;
    bad_r       <= bad_nxt;
    idx_r       <= idx_nxt;
    hit_start_r <= hit_start_nxt;
    hit_size_r  <= hit_size_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (gm_we) begin
      gran_mem_r[gm_waddr] <= gm_wdata;
    end
    if (gm_re) begin
      gm_rd_r <= gran_mem_r[gm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      flist_mem_r[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      fm_rd_r <= flist_mem_r[fm_raddr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

### rtl/first_fit_free_list_allocator.sv
// Free: the granule table entry is read, then checked, and the result is registered.
// Allocate: one free-list memory read per entry searched, and after a hit one
// read/write per entry moved down.
// Next item is accepted in the cycle the result strobe is shown; receiver cannot stall.
// Reset (synchronous, rst_n low) sets break to the header size, clears count and the
// result strobe, then sweeps HEAP_BYTES/8 granule entries (256 by default), busy high.
`default_nettype none
module first_fit_free_list_allocator #(
  parameter int HEAP_BYTES      = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
  parameter int FREE_LIST_DEPTH = ffa_pkg::FREE_LIST_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ffa_pkg::ffa_in_t           in_item,
  output logic                            out_valid,
  output ffa_pkg::ffa_out_t               out_item,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ffa_pkg::APB_AW-1:0] paddr,
  input  wire logic [ffa_pkg::APB_DW-1:0] pwdata,
  output logic      [ffa_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);

  logic [ffa_pkg::LIMIT_W-1:0] heap_limit;

  ffa_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .heap_limit (heap_limit)
  );

  ffa_ctrl #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .FREE_LIST_DEPTH (FREE_LIST_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .heap_limit (heap_limit),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

### rtl/ffa_checker.sv
`default_nettype none
module ffa_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire ffa_pkg::ffa_out_t out_item
);

  // an accepted item always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ffa_pkg::ST_OK) |->
      (out_item.result_offset == '0) && (out_item.block_bytes == '0))
    else $error("failure result carries nonzero fields");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
